### src/bcntm_pkg.sv
// ----------------------------------------------------------------------------
// bcntm_pkg
// Shared widths, codes, state type and pipeline result type of the tile matcher.
// ----------------------------------------------------------------------------
package bcntm_pkg;

    localparam int CH_W       = 12;
    localparam int PAL_W      = 3 * CH_W;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 13;
    localparam int TILE_W     = 9;
    localparam int DOUT_W     = 26;
    localparam int DIST_W     = 32;
    localparam int REQ_W      = 2;
    localparam int IDX_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int BS_W       = 7;
    localparam int EIU_W      = 10;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_REPEAT = 2'd2;

    localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = 7'd8;
    localparam logic [EIU_W-1:0] ENTRIES_RST      = 10'd300;
    localparam logic             ALLOW_REPEAT_RST = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              skip;
        logic [DIST_W-1:0] dsq;
    } dist_res_t;

endpackage

### src/block_color_nearest_tile_match.sv
// ----------------------------------------------------------------------------
// block_color_nearest_tile_match
// Block average color against a palette of tile averages; nearest free tile.
// ----------------------------------------------------------------------------
// Load and pixel transfers: accepted one per cycle while the input is not stalled, no result.
// Block-closing pixel: divide, one palette read per cycle for entries_in_use
//   entries, pipe drain, then the result; input stalled throughout.
// Clear transfer: sweep of every entry of the used-mark memory, input stalled.
// Reset: async, control cleared, then the same sweep of the used-mark memory.
module block_color_nearest_tile_match #(
    parameter int PALETTE_DEPTH  = 512,
    parameter int MAX_BLOCK_EDGE = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bcntm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcntm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bcntm_pkg::REQ_W-1:0]      req_type,
    input  logic [bcntm_pkg::IDX_W-1:0]      entry_index,
    input  logic [bcntm_pkg::CH_W-1:0]       avg_red,
    input  logic [bcntm_pkg::CH_W-1:0]       avg_green,
    input  logic [bcntm_pkg::CH_W-1:0]       avg_blue,
    input  logic [bcntm_pkg::PIX_W-1:0]      pixel_red,
    input  logic [bcntm_pkg::PIX_W-1:0]      pixel_green,
    input  logic [bcntm_pkg::PIX_W-1:0]      pixel_blue,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bcntm_pkg::TILE_W-1:0]     tile_index,
    output logic [bcntm_pkg::DOUT_W-1:0]     distance_sq,
    output logic                             none_free
);

    localparam int AW     = $clog2(PALETTE_DEPTH);
    localparam int LIM_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int EW     = $clog2(MAX_BLOCK_EDGE + 1);
    localparam int NW     = 2 * EW;
    localparam int SUM_W  = bcntm_pkg::SUM_W;
    localparam int CNT_W  = bcntm_pkg::CNT_W;
    localparam int SH_W   = SUM_W + 4;
    localparam int NUM_W  = ((SH_W > NW - 1) ? SH_W : NW - 1) + 1;
    localparam int DIST_W = bcntm_pkg::DIST_W;
    localparam int TILE_W = bcntm_pkg::TILE_W;
    localparam int DOUT_W = bcntm_pkg::DOUT_W;

    bcntm_pkg::state_t state_reg, state_next;

    logic [bcntm_pkg::BS_W-1:0]  block_size_reg;
    logic [bcntm_pkg::EIU_W-1:0] entries_reg;
    logic                        allow_repeat_reg;

    logic [SUM_W-1:0]  sum_r_reg, sum_r_next, sum_g_reg, sum_g_next, sum_b_reg, sum_b_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [LIM_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [AW-1:0]     best_i_reg, best_i_next;
    logic              out_valid_reg, out_valid_next;
    logic [TILE_W-1:0] tile_index_reg, tile_index_next;
    logic [DOUT_W-1:0] distance_sq_reg, distance_sq_next;
    logic              none_free_reg, none_free_next;

    logic              accept;
    logic              in_range;
    logic [EW-1:0]     edge_w;
    logic [NW-1:0]     n_w;
    logic [LIM_W-1:0]  limit_w;
    logic [SUM_W-1:0]  sum_r_add, sum_g_add, sum_b_add;
    logic [CNT_W-1:0]  count_inc;
    logic              blk_done;
    logic [NUM_W-1:0]  num_r, num_g, num_b;
    logic [NUM_W-1:0]  avg_r, avg_g, avg_b;
    logic              div_start, div_done;

    logic              pal_we;
    logic              used_we, used_wdata;
    logic [AW-1:0]     used_waddr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [bcntm_pkg::PAL_W-1:0] rd_pal;
    logic              rd_used;

    bcntm_pkg::dist_res_t res;
    logic [AW-1:0]        res_idx;
    logic                 dist_busy;
    logic                 cmp_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= bcntm_pkg::BLOCK_SIZE_RST;
            entries_reg      <= bcntm_pkg::ENTRIES_RST;
            allow_repeat_reg <= bcntm_pkg::ALLOW_REPEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcntm_pkg::CFG_BLOCK_SIZE:   block_size_reg   <= cfg_data[bcntm_pkg::BS_W-1:0];
                bcntm_pkg::CFG_ENTRIES:      entries_reg      <= cfg_data[bcntm_pkg::EIU_W-1:0];
                bcntm_pkg::CFG_ALLOW_REPEAT: allow_repeat_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_stall = (state_reg != bcntm_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(entry_index) < PALETTE_DEPTH);

    always_comb
    begin
        if (block_size_reg == '0)
        begin
            edge_w = EW'(1);
        end
        else if (32'(block_size_reg) > MAX_BLOCK_EDGE)
        begin
            edge_w = EW'(MAX_BLOCK_EDGE);
        end
        else
        begin
            edge_w = EW'(block_size_reg);
        end
        if (32'(entries_reg) > PALETTE_DEPTH)
        begin
            limit_w = LIM_W'(PALETTE_DEPTH);
        end
        else
        begin
            limit_w = LIM_W'(entries_reg);
        end
    end

    assign n_w       = NW'(edge_w) * NW'(edge_w);
    assign sum_r_add = sum_r_reg + SUM_W'(pixel_red);
    assign sum_g_add = sum_g_reg + SUM_W'(pixel_green);
    assign sum_b_add = sum_b_reg + SUM_W'(pixel_blue);
    assign count_inc = count_reg + 1'b1;
    assign blk_done  = (32'(count_inc) >= 32'(n_w));
    assign num_r     = NUM_W'({sum_r_add, 4'b0000}) + NUM_W'(n_w >> 1);
    assign num_g     = NUM_W'({sum_g_add, 4'b0000}) + NUM_W'(n_w >> 1);
    assign num_b     = NUM_W'({sum_b_add, 4'b0000}) + NUM_W'(n_w >> 1);

    assign cmp_take = res.valid && !res.skip && (!found_reg || (res.dsq < best_d_reg));

    always_comb
    begin
        state_next       = state_reg;
        sum_r_next       = sum_r_reg;
        sum_g_next       = sum_g_reg;
        sum_b_next       = sum_b_reg;
        count_next       = count_reg;
        clr_idx_next     = clr_idx_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        best_d_next      = best_d_reg;
        best_i_next      = best_i_reg;
        out_valid_next   = out_valid_reg;
        tile_index_next  = tile_index_reg;
        distance_sq_next = distance_sq_reg;
        none_free_next   = none_free_reg;
        pal_we           = 1'b0;
        used_we          = 1'b0;
        used_waddr       = clr_idx_reg;
        used_wdata       = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = scan_idx_reg[AW-1:0];
        div_start        = 1'b0;

        if (cmp_take)
        begin
            found_next  = 1'b1;
            best_d_next = res.dsq;
            best_i_next = res_idx;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bcntm_pkg::ST_CLEAR:
            begin
                used_we      = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(PALETTE_DEPTH - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = bcntm_pkg::ST_IDLE;
                end
            end
            bcntm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        bcntm_pkg::REQ_LOAD:
                        begin
                            pal_we = in_range;
                        end
                        bcntm_pkg::REQ_PIXEL:
                        begin
                            sum_r_next = sum_r_add;
                            sum_g_next = sum_g_add;
                            sum_b_next = sum_b_add;
                            count_next = count_inc;
                            if (blk_done)
                            begin
                                div_start  = 1'b1;
                                sum_r_next = '0;
                                sum_g_next = '0;
                                sum_b_next = '0;
                                count_next = '0;
                                state_next = bcntm_pkg::ST_DIV;
                            end
                        end
                        bcntm_pkg::REQ_CLEAR:
                        begin
                            state_next = bcntm_pkg::ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            bcntm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    found_next    = 1'b0;
                    scan_idx_next = '0;
                    state_next    = (limit_w == '0) ? bcntm_pkg::ST_RESULT
                                                    : bcntm_pkg::ST_SCAN;
                end
            end
            bcntm_pkg::ST_SCAN:
            begin
                rd_en         = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == limit_w - 1'b1)
                begin
                    state_next = bcntm_pkg::ST_DRAIN;
                end
            end
            bcntm_pkg::ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = bcntm_pkg::ST_RESULT;
                end
            end
            bcntm_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    tile_index_next  = found_reg ? TILE_W'(best_i_reg) : '0;
                    distance_sq_next = found_reg ? best_d_reg[DOUT_W-1:0] : '0;
                    none_free_next   = !found_reg;
                    used_we          = !allow_repeat_reg;
                    used_waddr       = found_reg ? best_i_reg : '0;
                    used_wdata       = 1'b1;
                    state_next       = bcntm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcntm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcntm_pkg::ST_CLEAR;
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_r_reg     <= sum_r_next;
            sum_g_reg     <= sum_g_next;
            sum_b_reg     <= sum_b_next;
            count_reg     <= count_next;
            clr_idx_reg   <= clr_idx_next;
            scan_idx_reg  <= scan_idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_d_reg      <= best_d_next;
        best_i_reg      <= best_i_next;
        tile_index_reg  <= tile_index_next;
        distance_sq_reg <= distance_sq_next;
        none_free_reg   <= none_free_next;
    end

    bcntm_div #(
        .NUM_W (NUM_W),
        .DEN_W (NW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_r  (num_r),
        .num_g  (num_g),
        .num_b  (num_b),
        .den    (n_w),
        .done   (div_done),
        .quot_r (avg_r),
        .quot_g (avg_g),
        .quot_b (avg_b)
    );

    bcntm_store #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk        (clk),
        .pal_we     (pal_we),
        .pal_waddr  (AW'(entry_index)),
        .pal_wdata  ({avg_red, avg_green, avg_blue}),
        .used_we    (used_we),
        .used_waddr (used_waddr),
        .used_wdata (used_wdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_pal     (rd_pal),
        .rd_used    (rd_used)
    );

    bcntm_dist #(
        .AW    (AW),
        .AVG_W (NUM_W)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (rd_en),
        .issue_idx    (rd_addr),
        .allow_repeat (allow_repeat_reg),
        .pal_data     (rd_pal),
        .used_bit     (rd_used),
        .avg_r        (avg_r),
        .avg_g        (avg_g),
        .avg_b        (avg_b),
        .res          (res),
        .res_idx      (res_idx),
        .busy         (dist_busy)
    );

    assign out_valid   = out_valid_reg;
    assign tile_index  = tile_index_reg;
    assign distance_sq = distance_sq_reg;
    assign none_free   = none_free_reg;

endmodule

### src/bcntm_div.sv
// ----------------------------------------------------------------------------
// bcntm_div
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module bcntm_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num_r,
    input  logic [NUM_W-1:0] num_g,
    input  logic [NUM_W-1:0] num_b,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot_r,
    output logic [NUM_W-1:0] quot_g,
    output logic [NUM_W-1:0] quot_b
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg  [3];
    logic [NUM_W-1:0] quo_next [3];
    logic [DEN_W-1:0] rem_reg  [3];
    logic [DEN_W-1:0] rem_next [3];
    logic [DEN_W:0]   trial    [3];
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = {rem_reg[k], quo_reg[k][NUM_W-1]};
            if (trial[k] >= {1'b0, den_reg})
            begin
                rem_next[k] = DEN_W'(trial[k] - {1'b0, den_reg});
                quo_next[k] = {quo_reg[k][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][DEN_W-1:0];
                quo_next[k] = {quo_reg[k][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NUM_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg[0] <= num_r;
            quo_reg[1] <= num_g;
            quo_reg[2] <= num_b;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= '0;
            end
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                quo_reg[k] <= quo_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    assign done   = done_reg;
    assign quot_r = quo_reg[0];
    assign quot_g = quo_reg[1];
    assign quot_b = quo_reg[2];

endmodule

### src/bcntm_store.sv
// ----------------------------------------------------------------------------
// bcntm_store
// Palette memory and used-mark memory, one shared registered read port.
// ----------------------------------------------------------------------------
module bcntm_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                        clk,
    input  logic                        pal_we,
    input  logic [AW-1:0]               pal_waddr,
    input  logic [bcntm_pkg::PAL_W-1:0] pal_wdata,
    input  logic                        used_we,
    input  logic [AW-1:0]               used_waddr,
    input  logic                        used_wdata,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [bcntm_pkg::PAL_W-1:0] rd_pal,
    output logic                        rd_used
);

    logic [bcntm_pkg::PAL_W-1:0] pal_mem [DEPTH];
    logic                        used_mem [DEPTH];
    logic [bcntm_pkg::PAL_W-1:0] rd_pal_reg;
    logic                        rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        if (rd_en)
        begin
            rd_pal_reg <= pal_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (rd_en)
        begin
            rd_used_reg <= used_mem[rd_addr];
        end
    end

    assign rd_pal  = rd_pal_reg;
    assign rd_used = rd_used_reg;

endmodule

### src/bcntm_dist.sv
// ----------------------------------------------------------------------------
// bcntm_dist
// Distance pipe: channel differences, squares, sum. One entry per cycle.
// ----------------------------------------------------------------------------
module bcntm_dist #(
    parameter int AW    = 9,
    parameter int AVG_W = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        issue,
    input  logic [AW-1:0]               issue_idx,
    input  logic                        allow_repeat,
    input  logic [bcntm_pkg::PAL_W-1:0] pal_data,
    input  logic                        used_bit,
    input  logic [AVG_W-1:0]            avg_r,
    input  logic [AVG_W-1:0]            avg_g,
    input  logic [AVG_W-1:0]            avg_b,
    output bcntm_pkg::dist_res_t        res,
    output logic [AW-1:0]               res_idx,
    output logic                        busy
);

    localparam int CH_W   = bcntm_pkg::CH_W;
    localparam int PAL_W  = bcntm_pkg::PAL_W;
    localparam int DIST_W = bcntm_pkg::DIST_W;
    localparam int PROD_W = 2 * AVG_W;

    logic [AVG_W-1:0]  avg   [3];
    logic [CH_W-1:0]   ch    [3];
    logic [AVG_W-1:0]  ch_x  [3];
    logic [AVG_W-1:0]  diff  [3];
    logic [PROD_W-1:0] prod  [3];
    logic [DIST_W-1:0] sum_w;

    logic              s0_valid_reg;
    logic [AW-1:0]     s0_idx_reg;
    logic              s1_valid_reg;
    logic              s1_skip_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic [AVG_W-1:0]  s1_d_reg [3];
    logic              s2_valid_reg;
    logic              s2_skip_reg;
    logic [AW-1:0]     s2_idx_reg;
    logic [DIST_W-1:0] s2_sq_reg [3];
    logic              s3_valid_reg;
    logic              s3_skip_reg;
    logic [AW-1:0]     s3_idx_reg;
    logic [DIST_W-1:0] s3_dist_reg;

    assign avg[0] = avg_r;
    assign avg[1] = avg_g;
    assign avg[2] = avg_b;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ch[k]   = pal_data[PAL_W-1-CH_W*k -: CH_W];
            ch_x[k] = AVG_W'(ch[k]);
            diff[k] = (ch_x[k] > avg[k]) ? ch_x[k] - avg[k] : avg[k] - ch_x[k];
            prod[k] = s1_d_reg[k] * s1_d_reg[k];
        end
        sum_w = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_idx_reg  <= issue_idx;
        s1_idx_reg  <= s0_idx_reg;
        s1_skip_reg <= !allow_repeat && used_bit;
        s2_idx_reg  <= s1_idx_reg;
        s2_skip_reg <= s1_skip_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_skip_reg <= s2_skip_reg;
        s3_dist_reg <= sum_w;
        for (int k = 0; k < 3; k++)
        begin
            s1_d_reg[k]  <= diff[k];
            s2_sq_reg[k] <= prod[k][DIST_W-1:0];
        end
    end

    assign res     = '{valid: s3_valid_reg, skip: s3_skip_reg, dsq: s3_dist_reg};
    assign res_idx = s3_idx_reg;
    assign busy    = s0_valid_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule

### src/bcntm_chk.sv
// ----------------------------------------------------------------------------
// bcntm_chk
// Port-level checks of the tile matcher, bound to the top level.
// ----------------------------------------------------------------------------
module bcntm_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [bcntm_pkg::REQ_W-1:0]  req_type,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bcntm_pkg::TILE_W-1:0] tile_index,
    input logic [bcntm_pkg::DOUT_W-1:0] distance_sq,
    input logic                         none_free
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tile_index)
            && $stable(distance_sq) && $stable(none_free))
        else $error("result changed while stalled");

    a_none_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_free |-> (tile_index == '0) && (distance_sq == '0))
        else $error("none_free result not entry zero with zero distance");

    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input taken during used-mark sweep after reset");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == bcntm_pkg::REQ_CLEAR) |=> in_stall)
        else $error("clear transfer did not start the used-mark sweep");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == bcntm_pkg::REQ_LOAD) |=> !in_stall)
        else $error("load transfer stalled the input");

endmodule

bind block_color_nearest_tile_match bcntm_chk u_bcntm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tile_index  (tile_index),
    .distance_sq (distance_sq),
    .none_free   (none_free)
);
